[rtl/fibonacci_search_table_assert.svh]
//------------------------------------------------------------------------------
// Assertion macros for the Fibonacci search table
// Short forms for the clocked checks used in the block. All are sampled on
// aclk and are switched off while aresetn is low.
//------------------------------------------------------------------------------
`ifndef FIBONACCI_SEARCH_TABLE_ASSERT_SVH
`define FIBONACCI_SEARCH_TABLE_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define FST_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("fibonacci_search_table: same-cycle check failed");

// The consequent holds in the cycle after the antecedent.
`define FST_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("fibonacci_search_table: next-cycle check failed");

`endif

[rtl/fst_pkg.sv]
//------------------------------------------------------------------------------
// Fibonacci search table package
// Sizes, command and status codes shared by the table module and the testbench.
//------------------------------------------------------------------------------
package fst_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH = 128;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    // A Fibonacci number at or above the count may need one more bit than the count.
    localparam int FIB_W       = CNT_W + 1;
    localparam int KEY_W       = 32;

    // Command codes carried on s_tuser.
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_SEARCH = 2'd2;

    // Status codes carried on m_tuser.
    localparam logic [2:0] ST_CLEARED  = 3'd0;
    localparam logic [2:0] ST_APPENDED = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_FOUND    = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    // Search sequencer states.
    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_BUILD   = 6'b000010,
        S_PROBE   = 6'b000100,
        S_CMP     = 6'b001000,
        S_LAST    = 6'b010000,
        S_LASTCMP = 6'b100000
    } state_t;

endpackage

[rtl/fst_ram.sv]
//------------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
//------------------------------------------------------------------------------
module fst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/fibonacci_search_table.sv]
//------------------------------------------------------------------------------
// Fibonacci search table
// Stores up to TABLE_DEPTH signed keys and runs Fibonacci search over them.
//------------------------------------------------------------------------------
// Clear and append commands finish in the cycle they are accepted and their
// item appears on the result channel in the next cycle. A search first grows
// a Fibonacci triple in S_BUILD until it reaches the first Fibonacci number
// at or above the count, then runs probes; each probe passes through S_PROBE,
// which issues the read, and S_CMP, which compares, because the key store has
// one read port with registered data. Without a match it ends in S_LAST and,
// if the slot is stored, S_LASTCMP. An empty table answers in the next cycle.
// The block takes one item at a time and is not ready while a search runs or while a result waits on the output.
//------------------------------------------------------------------------------
module fibonacci_search_table
    import fst_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [KEY_W-1:0] s_tdata,   // [31:0] key (signed)
    input  logic [1:0]       s_tuser,   // [1:0] cmd
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,   // [6:0] index, [7] zero fill
    output logic [2:0]       m_tuser    // [2:0] status
);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [FIB_W-1:0]   f_reg, f_next;
    logic [FIB_W-1:0]   f1_reg, f1_next;
    logic [FIB_W-1:0]   f2_reg, f2_next;
    logic [CNT_W-1:0]   basep1_reg, basep1_next;
    logic [ADDR_W-1:0]  slot_reg, slot_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [2:0]         status_reg, status_next;
    logic [ADDR_W-1:0]  index_reg, index_next;

    logic               in_accept;
    logic               out_free;
    logic               wr_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [KEY_W-1:0]   rd_data;
    logic [FIB_W:0]     probe_sum;
    logic [FIB_W:0]     probe_pos;
    logic [FIB_W:0]     last_slot;
    logic [ADDR_W-1:0]  slot_calc;
    logic [FIB_W-1:0]   f1_shrink;
    logic               have_lt;
    logic               have_eq;

    // Handshake: one item at a time, and only with room for its result.
    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE) && out_free;
    assign in_accept = s_tvalid && s_tready;

    // Append writes the next free slot.
    assign wr_en = in_accept && (s_tuser == CMD_APPEND) &&
                   (count_reg < CNT_W'(TABLE_DEPTH));

    // Probe position is base + f2, clamped to the stored range.
    assign probe_sum = {2'b00, basep1_reg} + {1'b0, f2_reg};
    assign last_slot = {2'b00, count_reg} - (FIB_W + 1)'(1);
    always_comb begin
        probe_pos = (probe_sum == '0) ? '0 : probe_sum - (FIB_W + 1)'(1);
        if (probe_pos > last_slot) begin
            probe_pos = last_slot;
        end
        slot_calc = probe_pos[ADDR_W-1:0];
    end

    assign rd_addr = (state_reg == S_LAST) ? basep1_reg[ADDR_W-1:0] : slot_calc;

    fst_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_key_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (s_tdata),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Shared compare of the stored key against the search key.
    assign have_lt   = $signed(rd_data) < $signed(key_reg);
    assign have_eq   = rd_data == key_reg;
    assign f1_shrink = f1_reg - f2_reg;

    // Sequencer.
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        key_next      = key_reg;
        f_next        = f_reg;
        f1_next       = f1_reg;
        f2_next       = f2_reg;
        basep1_next   = basep1_reg;
        slot_next     = slot_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        status_next   = status_reg;
        index_next    = index_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (in_accept) begin
                    key_next      = s_tdata;
                    m_tvalid_next = 1'b1;
                    index_next    = '0;
                    priority if (s_tuser == CMD_CLEAR) begin
                        count_next  = '0;
                        status_next = ST_CLEARED;
                    end else if (s_tuser == CMD_APPEND) begin
                        if (count_reg < CNT_W'(TABLE_DEPTH)) begin
                            count_next  = count_reg + CNT_W'(1);
                            status_next = ST_APPENDED;
                            index_next  = count_reg[ADDR_W-1:0];
                        end else begin
                            status_next = ST_FULL;
                        end
                    end else if (s_tuser == CMD_SEARCH && count_reg != '0) begin
                        m_tvalid_next = 1'b0;
                        f2_next       = '0;
                        f1_next       = FIB_W'(1);
                        f_next        = FIB_W'(1);
                        basep1_next   = '0;
                        state_next    = S_BUILD;
                    end else begin
                        status_next = ST_NOTFOUND;
                    end
                end
            end
            S_BUILD: begin
                // Grow the Fibonacci triple until it covers the count.
                if (f_reg < {1'b0, count_reg}) begin
                    f2_next = f1_reg;
                    f1_next = f_reg;
                    f_next  = f1_reg + f_reg;
                end else begin
                    state_next = S_PROBE;
                end
            end
            S_PROBE: begin
                // Issue the read of the next probe, or go to the final check.
                if (f_reg > FIB_W'(1)) begin
                    slot_next  = slot_calc;
                    state_next = S_CMP;
                end else begin
                    state_next = S_LAST;
                end
            end
            S_CMP: begin
                priority if (have_eq) begin
                    m_tvalid_next = 1'b1;
                    status_next   = ST_FOUND;
                    index_next    = slot_reg;
                    state_next    = S_IDLE;
                end else if (have_lt) begin
                    f_next      = f1_reg;
                    f1_next     = f2_reg;
                    f2_next     = f1_reg - f2_reg;
                    basep1_next = {1'b0, slot_reg} + CNT_W'(1);
                    state_next  = S_PROBE;
                end else begin
                    f_next     = f2_reg;
                    f1_next    = f1_shrink;
                    f2_next    = f2_reg - f1_shrink;
                    state_next = S_PROBE;
                end
            end
            S_LAST: begin
                // Single-slot check right after the base, if it is stored.
                if (f1_reg != '0 && basep1_reg < count_reg) begin
                    state_next = S_LASTCMP;
                end else begin
                    m_tvalid_next = 1'b1;
                    status_next   = ST_NOTFOUND;
                    index_next    = '0;
                    state_next    = S_IDLE;
                end
            end
            S_LASTCMP: begin
                m_tvalid_next = 1'b1;
                state_next    = S_IDLE;
                if (have_eq) begin
                    status_next = ST_FOUND;
                    index_next  = basep1_reg[ADDR_W-1:0];
                end else begin
                    status_next = ST_NOTFOUND;
                    index_next  = '0;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        key_reg    <= key_next;
        f_reg      <= f_next;
        f1_reg     <= f1_next;
        f2_reg     <= f2_next;
        basep1_reg <= basep1_next;
        slot_reg   <= slot_next;
        status_reg <= status_next;
        index_reg  <= index_next;
    end

    // Result channel.
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {1'b0, index_reg};

    `include "fibonacci_search_table_assert.svh"

    // The fill count never passes the table depth.
    `FST_ASSERT_SAME(a_count_range, 1'b1, count_reg <= CNT_W'(TABLE_DEPTH))
    // No result is offered while a search is running.
    `FST_ASSERT_SAME(a_busy_no_result, state_reg != S_IDLE, !m_tvalid_reg)
    // Every probe reads a stored slot.
    `FST_ASSERT_SAME(a_probe_in_range, state_reg == S_CMP, ({1'b0, slot_reg} < count_reg))
    // A search of an empty table answers not found at once.
    `FST_ASSERT_NEXT(a_empty_search,
        in_accept && s_tuser == CMD_SEARCH && count_reg == '0,
        m_tvalid_reg && status_reg == ST_NOTFOUND)

endmodule

[tb/tb_top.sv]
//------------------------------------------------------------------------------
// Testbench for the Fibonacci search table
// Drives clear, append and search commands through the stream input and
// checks every status and index on the result stream against a behavioral
// predictor. Sorted tables of random size are built and searched. A full
// table, an empty table, the unused command code and unsorted noise are
// mixed in, and both stream sides idle at random.
//------------------------------------------------------------------------------
module tb_top
    import fst_pkg::*;
();

    // Command code that the block does not decode; it answers not found.
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int         ITEMS      = 450;
    localparam int         CYCLE_CAP  = 500000;
    localparam int         DRAIN      = 40;

    typedef struct packed {
        logic [2:0] status;
        logic [6:0] index;
    } answer_t;

    // Predicts the answer to each command and holds the answers not yet seen.
    class search_oracle;
        logic signed [KEY_W-1:0] keys[TABLE_DEPTH];
        int                      count;
        answer_t                 pending_answers[$];
        int                      errors;

        function new();
            count  = 0;
            errors = 0;
        endfunction

        function int pending();
            return pending_answers.size();
        endfunction

        // Fibonacci search over the stored keys, probing in the fixed order.
        function answer_t fib_lookup(logic signed [KEY_W-1:0] key);
            int      n, fa, fb, fc, base, probe, last;
            answer_t a;
            a.status = ST_NOTFOUND;
            a.index  = '0;
            n        = count;
            if (n == 0) begin
                return a;
            end
            fa = 0;
            fb = 1;
            fc = 1;
            while (fc < n) begin
                fa = fb;
                fb = fc;
                fc = fa + fb;
            end
            base = -1;
            while (fc > 1) begin
                probe = base + fa;
                if (probe < 0) begin
                    probe = 0;
                end
                if (probe > n - 1) begin
                    probe = n - 1;
                end
                if (keys[probe] < key) begin
                    fc   = fb;
                    fb   = fa;
                    fa   = fc - fb;
                    base = probe;
                end else if (keys[probe] > key) begin
                    fc = fa;
                    fb = fb - fa;
                    fa = fc - fb;
                end else begin
                    a.status = ST_FOUND;
                    a.index  = 7'(probe);
                    return a;
                end
            end
            // The single remaining slot is only checked when it lies below the count.
            if (fb != 0) begin
                last = base + 1;
                if (last < n && keys[last] == key) begin
                    a.status = ST_FOUND;
                    a.index  = 7'(last);
                end
            end
            return a;
        endfunction

        function void note_command(logic [1:0] cmd, logic [KEY_W-1:0] key);
            answer_t a;
            a.status = ST_NOTFOUND;
            a.index  = '0;
            case (cmd)
                CMD_CLEAR: begin
                    count    = 0;
                    a.status = ST_CLEARED;
                end
                CMD_APPEND: begin
                    if (count >= TABLE_DEPTH) begin
                        a.status = ST_FULL;
                    end else begin
                        keys[count] = key;
                        a.status    = ST_APPENDED;
                        a.index     = 7'(count);
                        count++;
                    end
                end
                CMD_SEARCH: begin
                    a = fib_lookup(key);
                end
                default: begin
                end
            endcase
            pending_answers.push_back(a);
        endfunction

        function void check_answer(logic [2:0] status, logic [7:0] data);
            answer_t a;
            if (pending_answers.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("tb_top: result with nothing expected: status %0d index %0d",
                             status, data);
                end
                return;
            end
            a = pending_answers.pop_front();
            if (status !== a.status || data !== {1'b0, a.index}) begin
                errors++;
                if (errors <= 10) begin
                    $display("tb_top: mismatch: expected status %0d index %0d, got %0d %0d",
                             a.status, a.index, status, data);
                end
            end
        endfunction
    endclass

    logic             aclk;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [KEY_W-1:0] s_tdata;
    logic [1:0]       s_tuser;
    logic             m_tvalid;
    logic             m_tready;
    logic [7:0]       m_tdata;
    logic [2:0]       m_tuser;

    search_oracle oracle;
    int           cycles;
    int           sent;
    int           burst_left;
    int           ready_left;
    int           ready_mode;

    fibonacci_search_table dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Receiver stalls: each stretch picks a ready pattern, some never stall.
    always @(negedge aclk) begin
        if (ready_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            ready_left = $urandom_range(8, 60);
        end else begin
            ready_left = ready_left - 1;
        end
        case (ready_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (ready_left % 5 != 0);
        endcase
    end

    // Monitor both channels on the rising edge; results before commands.
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_CAP) begin
            $display("tb_top: done, errors");
            $finish;
        end else if (aresetn) begin
            if (m_tvalid && m_tready) begin
                oracle.check_answer(m_tuser, m_tdata);
            end
            if (s_tvalid && s_tready) begin
                oracle.note_command(s_tuser, s_tdata);
            end
        end
    end

    // Send one item; called and returning at a falling edge. Items go out in
    // bursts with random gaps between them.
    task automatic send_item(input logic [1:0] cmd, input logic [KEY_W-1:0] key);
        int gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 7) == 0) begin
                burst_left = 40;
                gap        = 0;
            end else begin
                burst_left = $urandom_range(1, 12);
                gap        = $urandom_range(0, 6);
            end
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= key;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        @(negedge aclk);
        sent++;
    endtask

    // Clear, append n keys in ascending order, then search for stored keys,
    // near misses and random keys. More than TABLE_DEPTH keys runs into full.
    task automatic run_sorted_set(input int n, input bit narrow, input int searches);
        int vals[$];
        int k;
        send_item(CMD_CLEAR, $urandom);
        for (int i = 0; i < n; i++) begin
            vals.push_back(narrow ? int'($urandom_range(0, 60)) - 30 : int'($urandom));
        end
        vals.sort();
        foreach (vals[i]) begin
            send_item(CMD_APPEND, vals[i]);
        end
        repeat (searches) begin
            if (vals.size() == 0) begin
                k = narrow ? int'($urandom_range(0, 60)) - 30 : int'($urandom);
            end else begin
                k = vals[$urandom_range(0, vals.size() - 1)];
                case ($urandom_range(0, 5))
                    0:       k = k + 1;
                    1:       k = k - 1;
                    2:       k = int'($urandom);
                    default: ;
                endcase
            end
            send_item(CMD_SEARCH, k);
        end
    endtask

    // Stimulus.
    initial begin
        oracle     = new();
        sent       = 0;
        burst_left = 0;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = CMD_CLEAR;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: empty table, unused code, extreme keys, single entry.
        send_item(CMD_SEARCH, 32'h0000_0000);
        send_item(CMD_UNUSED, 32'h1234_5678);
        send_item(CMD_CLEAR, 32'hFFFF_FFFF);
        send_item(CMD_SEARCH, 32'h8000_0000);
        send_item(CMD_APPEND, 32'h8000_0000);
        send_item(CMD_APPEND, 32'hFFFF_FFFF);
        send_item(CMD_APPEND, 32'h0000_0000);
        send_item(CMD_APPEND, 32'h0000_0001);
        send_item(CMD_APPEND, 32'h7FFF_FFFF);
        send_item(CMD_SEARCH, 32'h8000_0000);
        send_item(CMD_SEARCH, 32'hFFFF_FFFF);
        send_item(CMD_SEARCH, 32'h0000_0000);
        send_item(CMD_SEARCH, 32'h0000_0001);
        send_item(CMD_SEARCH, 32'h7FFF_FFFF);
        send_item(CMD_SEARCH, 32'h0000_0005);
        send_item(CMD_SEARCH, 32'hFFFF_FFFE);
        send_item(CMD_SEARCH, 32'h8000_0001);
        send_item(CMD_UNUSED, 32'hFFFF_FFFF);
        send_item(CMD_CLEAR, 32'h0000_0000);
        send_item(CMD_APPEND, 32'h0000_0007);
        send_item(CMD_SEARCH, 32'h0000_0007);
        send_item(CMD_SEARCH, 32'h0000_0008);
        send_item(CMD_SEARCH, 32'h0000_0006);

        // Random: a full table first, then mostly sorted sets, some noise.
        run_sorted_set(TABLE_DEPTH + 2, 1'b0, 24);
        while (sent < ITEMS) begin
            case ($urandom_range(0, 9))
                0: run_sorted_set(TABLE_DEPTH + $urandom_range(0, 2), 1'b1, 20);
                8, 9: begin
                    repeat ($urandom_range(1, 8)) begin
                        send_item(2'($urandom_range(0, 3)), $urandom);
                    end
                end
                default: run_sorted_set($urandom_range(0, 24), 1'($urandom_range(0, 1)),
                                        $urandom_range(4, 16));
            endcase
        end
        s_tvalid <= 1'b0;

        // Drain outstanding results, then give the block time for strays.
        while (oracle.pending() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN) @(posedge aclk);
        if (oracle.errors == 0 && oracle.pending() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
